// ===== rtl/core/svi_pkg.sv =====
`default_nettype none

package svi_pkg;

  // Error codes
  localparam logic [3:0] ERR_OK         = 4'd0;
  localparam logic [3:0] ERR_STRIKE     = 4'd1;
  localparam logic [3:0] ERR_FORWARD    = 4'd2;
  localparam logic [3:0] ERR_EXPIRY_NEG = 4'd3;
  localparam logic [3:0] ERR_SLOPE      = 4'd4;
  localparam logic [3:0] ERR_RHO        = 4'd5;
  localparam logic [3:0] ERR_SIGMA      = 4'd6;
  localparam logic [3:0] ERR_EXPIRY_0   = 4'd7;
  localparam logic [3:0] ERR_NEG_VAR    = 4'd8;

  // Register indexes
  localparam logic [3:0] REG_LEVEL_A   = 4'd0;
  localparam logic [3:0] REG_SLOPE_B   = 4'd1;
  localparam logic [3:0] REG_SKEW_RHO  = 4'd2;
  localparam logic [3:0] REG_SHIFT_M   = 4'd3;
  localparam logic [3:0] REG_SIGMA     = 4'd4;
  localparam logic [3:0] REG_FORWARD   = 4'd5;
  localparam logic [3:0] REG_EXPIRY    = 4'd6;
  localparam logic [3:0] REG_CHECK     = 4'd7;

  // Fixed-point constants
  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // Pipeline depths
  localparam int LOG_STEPS  = 30;
  localparam int LOG_LAT    = LOG_STEPS + 1;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;

endpackage

`default_nettype wire

// ===== rtl/core/svi_log2.sv =====
`default_nettype none

module svi_log2 #(
  parameter int SB_W = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [SB_W-1:0] sb_i,
  input  wire logic [31:0]     x0_i,
  input  wire logic [31:0]     x1_i,
  output logic                 valid_o,
  output logic [SB_W-1:0]      sb_o,
  output logic [34:0]          l0_o,
  output logic [34:0]          l1_o
);
  import svi_pkg::*;

  logic            valid_q [0:LOG_STEPS];
  logic [SB_W-1:0] sb_q    [0:LOG_STEPS];
  logic [30:0]     mant_q  [0:LOG_STEPS][0:1];
  logic [29:0]     frac_q  [0:LOG_STEPS][0:1];
  logic [4:0]      pos_q   [0:LOG_STEPS][0:1];

  logic [31:0] xin [0:1];
  assign xin[0] = x0_i;
  assign xin[1] = x1_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LOG_STEPS; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int i = 1; i <= LOG_STEPS; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // Normalize: find msb and align mantissa to [1,2) in Q.30
  for (genvar l = 0; l < 2; l++) begin : g_norm
    logic [4:0]  pos_d;
    logic [61:0] wide;
    always_comb begin
      pos_d = 5'd0;
      for (int i = 0; i < 32; i++) begin
        if (xin[l][i]) pos_d = 5'(i);
      end
      wide = {xin[l], 30'b0} >> pos_d;
    end
    always_ff @(posedge clk_i) begin
      mant_q[0][l] <= wide[30:0];
      frac_q[0][l] <= 30'b0;
      pos_q[0][l]  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb_i;
  end

  // One squaring step per stage, one fraction bit each
  for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_step
    always_ff @(posedge clk_i) begin
      sb_q[j] <= sb_q[j-1];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [61:0] sq;
      logic [31:0] m2;
      assign sq = mant_q[j-1][l] * mant_q[j-1][l];
      assign m2 = sq[61:30];
      always_ff @(posedge clk_i) begin
        pos_q[j][l] <= pos_q[j-1][l];
        if (m2[31]) begin
          mant_q[j][l] <= m2[31:1];
          frac_q[j][l] <= frac_q[j-1][l] | (30'd1 << (LOG_STEPS - j));
        end else begin
          mant_q[j][l] <= m2[30:0];
          frac_q[j][l] <= frac_q[j-1][l];
        end
      end
    end
  end

  assign valid_o = valid_q[LOG_STEPS];
  assign sb_o    = sb_q[LOG_STEPS];
  assign l0_o    = {pos_q[LOG_STEPS][0], frac_q[LOG_STEPS][0]};
  assign l1_o    = {pos_q[LOG_STEPS][1], frac_q[LOG_STEPS][1]};

endmodule

`default_nettype wire

// ===== rtl/core/svi_isqrt.sv =====
`default_nettype none

module svi_isqrt #(
  parameter int SB_W = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [SB_W-1:0] sb_i,
  input  wire logic [63:0]     x_i,
  output logic                 valid_o,
  output logic [SB_W-1:0]      sb_o,
  output logic [31:0]          root_o
);
  import svi_pkg::*;

  logic            valid_q [0:SQRT_STEPS-1];
  logic [SB_W-1:0] sb_q    [0:SQRT_STEPS-1];
  logic [63:0]     rem_q   [0:SQRT_STEPS-1];
  logic [63:0]     root_q  [0:SQRT_STEPS-1];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQRT_STEPS; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < SQRT_STEPS; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // One result bit per stage
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] rem_in, root_in, trial;
    logic [SB_W-1:0] sb_in;
    if (i == 0) begin : g_first
      assign rem_in  = x_i;
      assign root_in = 64'd0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign sb_in   = sb_q[i-1];
    end
    assign trial = root_in + BIT;
    always_ff @(posedge clk_i) begin
      sb_q[i] <= sb_in;
      if (rem_in >= trial) begin
        rem_q[i]  <= rem_in - trial;
        root_q[i] <= (root_in >> 1) + BIT;
      end else begin
        rem_q[i]  <= rem_in;
        root_q[i] <= root_in >> 1;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign sb_o    = sb_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

// ===== rtl/core/svi_div.sv =====
`default_nettype none

module svi_div #(
  parameter int SB_W = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [SB_W-1:0] sb_i,
  input  wire logic [46:0]     num_i,
  input  wire logic [31:0]     den_i,
  output logic                 valid_o,
  output logic [SB_W-1:0]      sb_o,
  output logic [63:0]          quot_o
);
  import svi_pkg::*;

  logic            valid_q [0:DIV_STEPS-1];
  logic [SB_W-1:0] sb_q    [0:DIV_STEPS-1];
  logic [31:0]     rem_q   [0:DIV_STEPS-1];
  logic [15:0]     nb_q    [0:DIV_STEPS-1];
  logic [63:0]     quot_q  [0:DIV_STEPS-1];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STEPS; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < DIV_STEPS; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // Restoring division of num * 2^48, one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [31:0] rem_in;
    logic [15:0] nb_in;
    logic [63:0] quot_in;
    logic [32:0] trial;
    logic [SB_W-1:0] sb_in;
    if (i == 0) begin : g_first
      assign rem_in  = {1'b0, num_i[46:16]};
      assign nb_in   = num_i[15:0];
      assign quot_in = 64'd0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign nb_in   = nb_q[i-1];
      assign quot_in = quot_q[i-1];
      assign sb_in   = sb_q[i-1];
    end
    assign trial = {rem_in, nb_in[15]};
    always_ff @(posedge clk_i) begin
      sb_q[i] <= sb_in;
      nb_q[i] <= {nb_in[14:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_q[i]  <= 32'(trial - {1'b0, den_i});
        quot_q[i] <= {quot_in[62:0], 1'b1};
      end else begin
        rem_q[i]  <= trial[31:0];
        quot_q[i] <= {quot_in[62:0], 1'b0};
      end
    end
  end

  assign valid_o = valid_q[DIV_STEPS-1];
  assign sb_o    = sb_q[DIV_STEPS-1];
  assign quot_o  = quot_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/svi_smile_volatility_top.sv =====
`default_nettype none

// Raw SVI implied volatility, one strike per clock. A strike is taken in every
// cycle (busy_o stays low) and its result comes out as a
// one-cycle result_valid_o strobe that cannot be held off. The depth comes
// from the 30-step log2 squaring chain, two 32-step bitwise square roots and
// the 64-step long division by the expiry, each resolved one step per stage.
// Slice registers are written through the cfg port and must be left alone
// while strikes are in flight; no clearing pass follows reset.
module svi_smile_volatility_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] strike_price_i,
  output logic             result_valid_o,
  output logic [31:0]      volatility_o,
  output logic [3:0]       error_code_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import svi_pkg::*;

  localparam int LATENCY = LOG_LAT + 9 + SQRT_STEPS + 5 + DIV_STEPS + SQRT_STEPS + 1;

  logic [31:0] level_a_q, slope_b_q, skew_rho_q, shift_m_q;
  logic [31:0] sigma_q, forward_q, expiry_q;
  logic        check_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Slice registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_a_q  <= 32'd0;
      slope_b_q  <= 32'd0;
      skew_rho_q <= 32'd0;
      shift_m_q  <= 32'd0;
      sigma_q    <= 32'd16777216;
      forward_q  <= 32'd65536;
      expiry_q   <= 32'd16777216;
      check_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEVEL_A:  level_a_q  <= cfg_data_i;
        REG_SLOPE_B:  slope_b_q  <= cfg_data_i;
        REG_SKEW_RHO: skew_rho_q <= cfg_data_i;
        REG_SHIFT_M:  shift_m_q  <= cfg_data_i;
        REG_SIGMA:    sigma_q    <= cfg_data_i;
        REG_FORWARD:  forward_q  <= cfg_data_i;
        REG_EXPIRY:   expiry_q   <= cfg_data_i;
        REG_CHECK:    check_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Magnitudes of the slice constants
  logic [31:0] tm, asg;
  logic [32:0] neg_t, neg_sg;
  assign neg_t  = 33'd0 - {expiry_q[31], expiry_q};
  assign neg_sg = 33'd0 - {sigma_q[31], sigma_q};
  assign tm     = expiry_q[31] ? neg_t[31:0] : expiry_q;
  assign asg    = sigma_q[31] ? neg_sg[31:0] : sigma_q;

  // Screen the beat on entry
  logic [3:0] err_in;
  always_comb begin
    err_in = ERR_OK;
    if ($signed(strike_price_i) <= 32'sd0) err_in = ERR_STRIKE;
    else if ($signed(forward_q) <= 32'sd0) err_in = ERR_FORWARD;
    else if (check_q) begin
      if ($signed(expiry_q) < 32'sd0) err_in = ERR_EXPIRY_NEG;
      else if ($signed(slope_b_q) < 32'sd0) err_in = ERR_SLOPE;
      else if ($signed(skew_rho_q) >= ONE_Q30 || $signed(skew_rho_q) <= -ONE_Q30)
        err_in = ERR_RHO;
      else if ($signed(sigma_q) <= 32'sd0) err_in = ERR_SIGMA;
    end
    if (err_in == ERR_OK && expiry_q == 32'd0) err_in = ERR_EXPIRY_0;
  end

  // Log2 of strike and forward
  logic        lg_v;
  logic [3:0]  lg_e;
  logic [34:0] lg_s, lg_f;

  svi_log2 #(.SB_W(4)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .sb_i    (err_in),
    .x0_i    (strike_price_i),
    .x1_i    (forward_q),
    .valid_o (lg_v),
    .sb_o    (lg_e),
    .l0_o    (lg_s),
    .l1_o    (lg_f)
  );

  // Valid and error code through the front stages
  logic       v_q [1:9];
  logic [3:0] e_q [1:9];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 9; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[1] <= lg_v;
      for (int i = 2; i <= 9; i++) v_q[i] <= v_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    e_q[1] <= lg_e;
    for (int i = 2; i <= 9; i++) e_q[i] <= e_q[i-1];
  end

  logic        [35:0] d1_q;
  logic        [17:0] dh2_q;
  logic        [45:0] pl2_q, pl3_q;
  logic signed [46:0] ph3_q;
  logic        [29:0] k4_q;
  logic        [32:0] u5_q, u6_q;
  logic        [31:0] au6_q, asg7_q;
  logic        [63:0] squ7_q, squ8_q, sqs8_q, x9_q;
  logic signed [48:0] rl7_q, rl8_q, rh8_q;
  logic        [16:0] uh7_q;
  logic        [33:0] ru9_q;

  logic [64:0] p4;
  logic [32:0] u5_d, neg_u;
  logic [64:0] ru_sum;
  assign p4     = {ph3_q, 18'b0} + {19'b0, pl3_q} + (65'd1 << 33);
  assign u5_d   = {{3{k4_q[29]}}, k4_q} - {shift_m_q[31], shift_m_q};
  assign neg_u  = 33'd0 - u5_q;
  assign ru_sum = {rh8_q, 16'b0} + {{16{rl8_q[48]}}, rl8_q} + (65'd1 << 29);

  // Log-moneyness, offset, squares and skew term
  always_ff @(posedge clk_i) begin
    d1_q   <= {1'b0, lg_s} - {1'b0, lg_f};
    dh2_q  <= d1_q[35:18];
    pl2_q  <= d1_q[17:0] * LN2_Q28;
    ph3_q  <= $signed(dh2_q) * $signed({1'b0, LN2_Q28});
    pl3_q  <= pl2_q;
    k4_q   <= p4[63:34];
    u5_q   <= u5_d;
    u6_q   <= u5_q;
    au6_q  <= u5_q[32] ? neg_u[31:0] : u5_q[31:0];
    squ7_q <= au6_q * au6_q;
    rl7_q  <= $signed(skew_rho_q) * $signed({1'b0, u6_q[15:0]});
    uh7_q  <= u6_q[32:16];
    asg7_q <= asg;
    squ8_q <= squ7_q;
    sqs8_q <= asg7_q * asg7_q;
    rh8_q  <= $signed(skew_rho_q) * $signed(uh7_q);
    rl8_q  <= rl7_q;
    x9_q   <= squ8_q + sqs8_q;
    ru9_q  <= ru_sum[63:30];
  end

  // Root of u^2 + sigma^2
  logic        rt_v;
  logic [37:0] rt_sb;
  logic [31:0] rt_root;

  svi_isqrt #(.SB_W(38)) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[9]),
    .sb_i    ({ru9_q, e_q[9]}),
    .x_i     (x9_q),
    .valid_o (rt_v),
    .sb_o    (rt_sb),
    .root_o  (rt_root)
  );

  // Valid and error code through the variance stages
  logic       vb_q [10:13];
  logic [3:0] eb_q [10:13];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 10; i <= 13; i++) vb_q[i] <= 1'b0;
    end else begin
      vb_q[10] <= rt_v;
      for (int i = 11; i <= 13; i++) vb_q[i] <= vb_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    eb_q[10] <= rt_sb[3:0];
    for (int i = 11; i <= 13; i++) eb_q[i] <= eb_q[i-1];
  end

  logic        [35:0] inner10_q;
  logic        [11:0] ih11_q;
  logic signed [56:0] bl11_q;
  logic signed [43:0] bh12_q;
  logic        [32:0] rr12_q;
  logic        [47:0] w13_q;
  logic        [56:0] bl_rnd;
  assign bl_rnd = bl11_q + (57'd1 << 23);

  // Total variance w = a + b * inner
  always_ff @(posedge clk_i) begin
    inner10_q <= {{2{rt_sb[37]}}, rt_sb[37:4]} + {4'b0, rt_root};
    ih11_q    <= inner10_q[35:24];
    bl11_q    <= $signed(slope_b_q) * $signed({1'b0, inner10_q[23:0]});
    bh12_q    <= $signed(slope_b_q) * $signed(ih11_q);
    rr12_q    <= bl_rnd[56:24];
    w13_q     <= {{16{level_a_q[31]}}, level_a_q} + {{4{bh12_q[43]}}, bh12_q}
                 + {{15{rr12_q[32]}}, rr12_q};
  end

  // Classify the variance and form the dividend
  logic        v14_q;
  logic [3:0]  e14_q;
  logic        z14_q, sat14_q;
  logic [46:0] wm14_q;
  logic [47:0] neg_w;
  logic [46:0] wm_d;
  assign neg_w = 48'd0 - w13_q;
  assign wm_d  = w13_q[47] ? neg_w[46:0] : w13_q[46:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v14_q <= 1'b0;
    else         v14_q <= vb_q[13];
  end
  always_ff @(posedge clk_i) begin
    if (eb_q[13] == ERR_OK && w13_q != 48'd0 && (w13_q[47] != expiry_q[31]))
      e14_q <= ERR_NEG_VAR;
    else
      e14_q <= eb_q[13];
    z14_q   <= (w13_q == 48'd0);
    sat14_q <= ({1'b0, wm_d} >= {tm, 16'b0});
    wm14_q  <= wm_d;
  end

  // Ratio w / T in Q.48
  logic        dv_v;
  logic [5:0]  dv_sb;
  logic [63:0] dv_q;

  svi_div #(.SB_W(6)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v14_q),
    .sb_i    ({e14_q, z14_q, sat14_q}),
    .num_i   (wm14_q),
    .den_i   (tm),
    .valid_o (dv_v),
    .sb_o    (dv_sb),
    .quot_o  (dv_q)
  );

  // Volatility root
  logic        vr_v;
  logic [5:0]  vr_sb;
  logic [31:0] vr_root;

  svi_isqrt #(.SB_W(6)) u_vol (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_v),
    .sb_i    (dv_sb),
    .x_i     (dv_q),
    .valid_o (vr_v),
    .sb_o    (vr_sb),
    .root_o  (vr_root)
  );

  // Drive the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else         result_valid_o <= vr_v;
  end
  always_ff @(posedge clk_i) begin
    error_code_o <= vr_sb[5:2];
    if (vr_sb[5:2] != ERR_OK || vr_sb[1]) volatility_o <= 32'd0;
    else if (vr_sb[0])                    volatility_o <= 32'hFFFF_FFFF;
    else                                  volatility_o <= vr_root;
  end

  // Checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY result_valid_o)
    else $error("strike did not produce a result at the expected latency");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching strike");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && error_code_o != ERR_OK) |-> volatility_o == 32'd0)
    else $error("error result carries a nonzero volatility");

endmodule

`default_nettype wire
